// ===== src/tgpe_pkg.sv =====
// Shared types and constants for the text glyph pixel expander.
package tgpe_pkg;

	localparam int unsigned SHORT_SIDE = 240;
	localparam int unsigned LONG_SIDE  = 320;
	localparam int unsigned CELL_W     = 8;
	localparam int unsigned CELL_H     = 16;
	localparam int unsigned BEATS      = 32;
	localparam int unsigned CMDQ_DEPTH = 2;

	localparam int unsigned BEAT_W = $clog2(BEATS);
	localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(BEATS - 1);

	localparam logic [10:0] SHORT_W = 11'(SHORT_SIDE);
	localparam logic [10:0] LONG_W  = 11'(LONG_SIDE);

	typedef enum logic [1:0] {
		REG_TEXT_COLOR = 2'd0,
		REG_BACK_COLOR = 2'd1,
		REG_SCAN_MODE  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [63:0] glyph_upper;
		logic [63:0] glyph_lower;
		logic        restart;
		logic [8:0]  start_line;
	} item_t;

	typedef struct packed {
		logic [8:0]  x_origin;
		logic [8:0]  y_origin;
		logic [3:0]  glyph_row;
		logic        half;
		logic [15:0] pixel_a;
		logic [15:0] pixel_b;
		logic [15:0] pixel_c;
		logic [15:0] pixel_d;
		logic        last;
	} pix_t;

	typedef struct packed {
		logic [127:0] glyph;
		logic [8:0]   x;
		logic [8:0]   y;
	} cmd_t;

endpackage

// ===== src/text_glyph_pixel_expander_core.sv =====
// Top level of the text glyph pixel expander: configuration registers and datapath.
// The first beat of a character passes through the command queue and then the output register.
// Throughput: 32 beats per character; one per cycle out of the output register unless stalled.
// A two-entry command queue lets a new character be accepted while the previous one drains.
// Reset clears the cursor, the queue and the beat counter; colors reset to white on black.
module text_glyph_pixel_expander_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  tgpe_pkg::item_t item,
	output logic            pix_valid,
	input  logic            pix_ready,
	output tgpe_pkg::pix_t  pix,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data
);
	import tgpe_pkg::*;

	logic [15:0] text_color_q;
	logic [15:0] back_color_q;
	logic [2:0]  scan_mode_q;
	logic        f_cmd_valid;
	logic        f_cmd_ready;
	cmd_t        f_cmd;
	logic        b_cmd_valid;
	logic        b_cmd_pop;
	cmd_t        b_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= 16'hFFFF;
			back_color_q <= 16'h0000;
			scan_mode_q  <= 3'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEXT_COLOR: text_color_q <= cfg_data;
				REG_BACK_COLOR: back_color_q <= cfg_data;
				REG_SCAN_MODE:  scan_mode_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	tgpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.scan_odd   (scan_mode_q[0]),
		.cmd_valid  (f_cmd_valid),
		.cmd_ready  (f_cmd_ready),
		.cmd        (f_cmd)
	);

	tgpe_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_cmd_valid),
		.push_ready (f_cmd_ready),
		.push_data  (f_cmd),
		.pop_valid  (b_cmd_valid),
		.pop_ready  (b_cmd_pop),
		.pop_data   (b_cmd)
	);

	tgpe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (b_cmd_valid),
		.cmd_pop    (b_cmd_pop),
		.cmd        (b_cmd),
		.text_color (text_color_q),
		.back_color (back_color_q),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix        (pix)
	);

endmodule

// ===== src/tgpe_front.sv =====
// Front end: accepts characters, wraps the text cursor and issues draw commands.
module tgpe_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  tgpe_pkg::item_t item,
	input  logic           scan_odd,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output tgpe_pkg::cmd_t cmd
);
	import tgpe_pkg::*;

	logic [8:0]  col_q;
	logic [9:0]  row_q;
	logic [10:0] width;
	logic [10:0] height;
	logic [10:0] col0, row0, col1, row1, col2, row2;
	logic        accept;

	assign width  = scan_odd ? LONG_W : SHORT_W;
	assign height = scan_odd ? SHORT_W : LONG_W;

	always_comb begin
		if (item.restart) begin
			col0 = '0;
			row0 = {2'b00, item.start_line};
		end else begin
			col0 = {2'b00, col_q};
			row0 = {1'b0, row_q};
		end
		if (col0 + 11'(CELL_W) > width) begin
			col1 = '0;
			row1 = row0 + 11'(CELL_H);
		end else begin
			col1 = col0;
			row1 = row0;
		end
		if (row1 + 11'd1 > height) begin
			col2 = '0;
			row2 = '0;
		end else begin
			col2 = col1;
			row2 = row1;
		end
	end

	assign cmd_valid  = item_valid;
	assign item_ready = cmd_ready;
	assign accept     = item_valid && cmd_ready;

	assign cmd.glyph = {item.glyph_upper, item.glyph_lower};
	assign cmd.x     = col2[8:0];
	assign cmd.y     = row2[8:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col2[8:0] + 9'(CELL_W);
			row_q <= row2[9:0];
		end
	end

	a_col_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		col_q[2:0] == 3'd0)
		else $error("cursor column lost its cell alignment");

endmodule

// ===== src/tgpe_cmd_fifo.sv =====
// Short command queue between the front end and the pixel back end.
module tgpe_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  tgpe_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output tgpe_pkg::cmd_t pop_data
);
	import tgpe_pkg::*;

	localparam int unsigned PTR_W = $clog2(CMDQ_DEPTH);
	localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             ent_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(CMDQ_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = ent_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CMDQ_DEPTH))
		else $error("command queue count exceeds its depth");

endmodule

// ===== src/tgpe_back.sv =====
// Back end: expands one draw command into 32 four-pixel beats.
module tgpe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	input  tgpe_pkg::cmd_t cmd,
	input  logic [15:0]    text_color,
	input  logic [15:0]    back_color,
	output logic           pix_valid,
	input  logic           pix_ready,
	output tgpe_pkg::pix_t pix
);
	import tgpe_pkg::*;

	logic [BEAT_W-1:0] beat_q;
	logic              pix_valid_q;
	pix_t              pix_q;
	logic              load;
	logic [3:0]        grow;
	logic [7:0]        row_bits;
	logic [3:0]        nib;
	pix_t              beat;

	assign load     = cmd_valid && (!pix_valid_q || pix_ready);
	assign cmd_pop  = load && (beat_q == LAST_BEAT);
	assign grow     = beat_q[4:1];
	assign row_bits = cmd.glyph[{~grow, 3'b111} -: 8];
	assign nib      = beat_q[0] ? row_bits[3:0] : row_bits[7:4];

	always_comb begin
		beat.x_origin  = cmd.x;
		beat.y_origin  = cmd.y;
		beat.glyph_row = grow;
		beat.half      = beat_q[0];
		beat.pixel_a   = nib[3] ? text_color : back_color;
		beat.pixel_b   = nib[2] ? text_color : back_color;
		beat.pixel_c   = nib[1] ? text_color : back_color;
		beat.pixel_d   = nib[0] ? text_color : back_color;
		beat.last      = beat_q == LAST_BEAT;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pix_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= '0;
			pix_valid_q <= 1'b0;
		end else begin
			if (load) begin
				beat_q      <= beat_q + 1'b1;
				pix_valid_q <= 1'b1;
			end else if (pix_ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> beat_q == LAST_BEAT)
		else $error("command released before its final beat");

	a_last_beat: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix.last |-> pix.glyph_row == 4'hF && pix.half)
		else $error("final beat does not sit on the last glyph half row");

	a_load_counts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> beat_q == $past(beat_q) + 1'b1)
		else $error("beat counter did not advance on a loaded beat");

endmodule

// ===== tb/sv/tb_text_glyph_pixel_expander_core.sv =====
// Self-checking testbench for text_glyph_pixel_expander_core with a cursor and color predictor.
`timescale 1ns / 1ps

module tb_text_glyph_pixel_expander_core;
	import tgpe_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 3000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        pix_valid;
	logic        pix_ready = 1'b0;
	pix_t        pix;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_TEXT_COLOR;
	logic [15:0] cfg_data = '0;

	// Expected state of the block.
	logic [15:0] text_m = 16'hFFFF;
	logic [15:0] back_m = 16'h0000;
	logic [2:0]  scan_m = 3'd0;
	logic [8:0]  cursor_col = '0;
	logic [9:0]  cursor_row = '0;

	item_t glyph_q[$];
	pix_t  beats_q[$];

	int idle_odds = 5;
	int cells_taken = 0;
	int mismatches = 0;
	int beats_seen = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int idle_cycles = 0;

	text_glyph_pixel_expander_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic draw_cell(input item_t it);
		int unsigned wid;
		int unsigned hgt;
		int unsigned col;
		int unsigned row;
		int unsigned r;
		logic [63:0] src;
		logic [7:0]  bits;
		logic [15:0] px[4];
		pix_t b;
		if (scan_m[0]) begin
			wid = LONG_SIDE;
			hgt = SHORT_SIDE;
		end else begin
			wid = SHORT_SIDE;
			hgt = LONG_SIDE;
		end
		col = cursor_col;
		row = cursor_row;
		if (it.restart) begin
			col = 0;
			row = it.start_line;
		end
		if (col + CELL_W > wid) begin
			col = 0;
			row = row + CELL_H;
		end
		if (row + 1 > hgt) begin
			col = 0;
			row = 0;
		end
		for (int k = 0; k < BEATS; k++) begin
			r = k >> 1;
			src = (r < 8) ? it.glyph_upper : it.glyph_lower;
			bits = src[(7 - (r % 8)) * 8 +: 8];
			for (int j = 0; j < 4; j++)
				px[j] = bits[7 - ((k & 1) * 4 + j)] ? text_m : back_m;
			b.x_origin = 9'(col);
			b.y_origin = 9'(row);
			b.glyph_row = 4'(r);
			b.half = k[0];
			b.pixel_a = px[0];
			b.pixel_b = px[1];
			b.pixel_c = px[2];
			b.pixel_d = px[3];
			b.last = (k == BEATS - 1);
			beats_q.push_back(b);
		end
		cursor_col = 9'(col + CELL_W);
		cursor_row = 10'(row);
	endtask

	function automatic item_t glyph_cell(input logic [63:0] upper, input logic [63:0] lower,
			input logic restart, input logic [8:0] line);
		item_t it;
		it.glyph_upper = upper;
		it.glyph_lower = lower;
		it.restart = restart;
		it.start_line = line;
		return it;
	endfunction

	function automatic item_t random_cell();
		int unsigned hgt;
		logic [63:0] upper;
		logic [63:0] lower;
		logic [8:0]  line;
		hgt = scan_m[0] ? SHORT_SIDE : LONG_SIDE;
		case ($urandom_range(0, 9))
			0: begin
				upper = '0;
				lower = '0;
			end
			1: begin
				upper = '1;
				lower = '1;
			end
			default: begin
				upper = {$urandom, $urandom};
				lower = {$urandom, $urandom};
			end
		endcase
		if ($urandom_range(0, 3) == 0)
			line = 9'($urandom_range(0, 511));
		else
			line = 9'($urandom_range(0, hgt - 1));
		return glyph_cell(upper, lower, $urandom_range(0, 39) == 0, line);
	endfunction

	task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TEXT_COLOR: text_m = val;
			REG_BACK_COLOR: back_m = val;
			REG_SCAN_MODE: scan_m = val[2:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (glyph_q.size() != 0 || item_valid || beats_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic [15:0] fg, input logic [15:0] bg,
			input logic [2:0] scan, input int odds, input int count);
		wait_drained();
		set_reg(REG_TEXT_COLOR, fg);
		set_reg(REG_BACK_COLOR, bg);
		set_reg(REG_SCAN_MODE, {13'($urandom), scan});
		set_reg(REG_UNUSED, 16'($urandom));
		idle_odds = odds;
		repeat (count) glyph_q.push_back(random_cell());
	endtask

	function automatic void note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("beat %0d at %0t: %s", beats_seen, $realtime, what);
	endfunction

	always @(posedge clk) begin
		logic  offer;
		item_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			offer = item_valid;
			nxt = item;
			if (item_valid && item_ready) begin
				draw_cell(item);
				cells_taken++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (glyph_q.size() != 0) begin
					nxt = glyph_q.pop_front();
					offer = 1'b1;
					if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
						send_gap = $urandom_range(1, 14);
				end
			end
			item_valid <= offer;
			item <= nxt;
		end
	end

	// The receiver holds off once for a long stretch so the command queue fills up.
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_ready <= 1'b0;
		end else begin
			if (!hold_done && cells_taken >= 20) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				pix_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				pix_ready <= 1'b0;
			end else begin
				pix_ready <= 1'b1;
				if (idle_odds != 0 && $urandom_range(1, idle_odds * 4) == 1)
					recv_gap = $urandom_range(1, 14);
			end
		end
	end

	always @(posedge clk) begin
		pix_t  want;
		string diff;
		if (arst_n && pix_valid && pix_ready) begin
			if (beats_q.size() == 0) begin
				note_mismatch($sformatf("beat with no character pending: %h", pix));
			end else begin
				want = beats_q.pop_front();
				diff = "";
				if (pix.x_origin !== want.x_origin)
					diff = {diff, $sformatf(" x_origin %0d/%0d", want.x_origin, pix.x_origin)};
				if (pix.y_origin !== want.y_origin)
					diff = {diff, $sformatf(" y_origin %0d/%0d", want.y_origin, pix.y_origin)};
				if (pix.glyph_row !== want.glyph_row)
					diff = {diff, $sformatf(" glyph_row %0d/%0d", want.glyph_row, pix.glyph_row)};
				if (pix.half !== want.half)
					diff = {diff, $sformatf(" half %0d/%0d", want.half, pix.half)};
				if (pix.pixel_a !== want.pixel_a)
					diff = {diff, $sformatf(" pixel_a %h/%h", want.pixel_a, pix.pixel_a)};
				if (pix.pixel_b !== want.pixel_b)
					diff = {diff, $sformatf(" pixel_b %h/%h", want.pixel_b, pix.pixel_b)};
				if (pix.pixel_c !== want.pixel_c)
					diff = {diff, $sformatf(" pixel_c %h/%h", want.pixel_c, pix.pixel_c)};
				if (pix.pixel_d !== want.pixel_d)
					diff = {diff, $sformatf(" pixel_d %h/%h", want.pixel_d, pix.pixel_d)};
				if (pix.last !== want.last)
					diff = {diff, $sformatf(" last %0d/%0d", want.last, pix.last)};
				if (diff != "")
					note_mismatch({"expected/actual", diff});
			end
			beats_seen++;
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (pix_valid && pix_ready) || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset colors and portrait geometry: blank, solid and striped glyphs, then restarts
		// at the top, last row, just past the bottom, largest line value and near the last cell row.
		glyph_q.push_back(glyph_cell('0, '0, 1'b0, 9'd0));
		glyph_q.push_back(glyph_cell('1, '1, 1'b0, 9'd511));
		glyph_q.push_back(glyph_cell({8{8'hAA}}, {8{8'h55}}, 1'b0, 9'd0));
		glyph_q.push_back(glyph_cell({8{8'h0F}}, {8{8'hF0}}, 1'b0, 9'd0));
		glyph_q.push_back(glyph_cell(64'h8040201008040201, 64'h0102040810204080, 1'b1, 9'd0));
		glyph_q.push_back(glyph_cell('1, '0, 1'b1, 9'(LONG_SIDE - 1)));
		glyph_q.push_back(glyph_cell('0, '1, 1'b0, 9'd0));
		glyph_q.push_back(glyph_cell({8{8'h81}}, {8{8'h18}}, 1'b1, 9'(LONG_SIDE)));
		glyph_q.push_back(glyph_cell('1, '1, 1'b1, 9'd511));
		glyph_q.push_back(glyph_cell({8{8'hC3}}, {8{8'h3C}}, 1'b1, 9'(LONG_SIDE - CELL_H)));
		glyph_q.push_back(glyph_cell('0, '1, 1'b1, 9'(LONG_SIDE - CELL_H + 1)));
		glyph_q.push_back(glyph_cell('1, '0, 1'b0, 9'd0));

		run_phase(16'h0000, 16'hFFFF, 3'd1, 4, 50);
		run_phase(16'hF800, 16'h07E0, 3'd7, 0, 50);
		run_phase(16'hFFFF, 16'hFFFF, 3'd6, 3, 50);
		run_phase(16'h0000, 16'h0000, 3'd3, 8, 50);
		run_phase(16'($urandom), 16'($urandom), 3'd4, 5, 50);
		run_phase(16'($urandom), 16'($urandom), 3'd5, 2, 50);
		run_phase(16'h001F, 16'hFFE0, 3'd2, 6, 50);
		run_phase(16'($urandom), 16'($urandom), 3'd0, 0, 50);

		wait_drained();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/tgpe_pkg.sv
src/tgpe_front.sv
src/tgpe_cmd_fifo.sv
src/tgpe_back.sv
src/text_glyph_pixel_expander_core.sv
tb/sv/tb_text_glyph_pixel_expander_core.sv
